// File: hdl/ddac_pkg.sv
// Shared constants, types and helper functions of the DDA ray column caster.
package ddac_pkg;

  // Map, screen and walk limits.
  localparam int MAP_SIZE  = 32;
  localparam int SCREEN_W  = 800;
  localparam int SCREEN_H  = 600;
  localparam int MAX_STEPS = 64;

  localparam int ONE_Q16   = 65536;
  localparam int ADDR_W    = $clog2(MAP_SIZE * MAP_SIZE);
  localparam int DEPTH     = MAP_SIZE * MAP_SIZE;
  localparam int CELL_W    = 4;
  localparam int COL_W     = 12;
  localparam int POS_W     = 21;
  localparam int VEC_W     = 18;
  localparam int RAY_W     = 19;
  localparam int DELTA_W   = 41;
  localparam int SUM_W     = 52;
  localparam int COORD_W   = 10;
  localparam int NUM_W     = 28;
  localparam int DIV_W     = 44;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 21;

  // Camera x is column * 2^17 / SCREEN_W minus one; the quotient is formed as a multiply by a
  // rounded-up reciprocal and a right shift; exact for every on-screen column.
  localparam int     CAM_SHIFT = 15;
  localparam longint CAM_RECIP = ((longint'(1) << (17 + CAM_SHIFT)) + SCREEN_W - 1) / SCREEN_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CAST,
    CMD_BAD
  } cmd_kind_e;

  // One classified item as it sits in the queue.
  typedef struct packed {
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   value;
    logic [COL_W-1:0]    column;
  } cmd_t;

  // Camera registers seen by the back end.
  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
  } cam_cfg_t;

  // Magnitude of a ray component.
  function automatic logic [RAY_W-1:0] abs_ray(input logic signed [RAY_W-1:0] v);
    logic [RAY_W-1:0] m;
    m = v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
    return m;
  endfunction

  // Saturate a wide signed row to 16 bits.
  function automatic logic signed [15:0] clamp16(input logic signed [DIV_W+1:0] v);
    logic signed [15:0] r;
    if (v < -(DIV_W+2)'(32768)) r = -16'sd32768;
    else if (v > (DIV_W+2)'(32767)) r = 16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: hdl/ddac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ddac_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/ddac_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ddac_div import ddac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/ddac_queue.sv
// Two-entry queue of classified commands between front and back end.
module ddac_queue import ddac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rptr_q];

endmodule

// File: hdl/ddac_front.sv
// Front end: takes command transfers, classifies them and feeds the queue.
module ddac_front import ddac_pkg::*; (
  input  logic              start_i,
  input  logic              action_i,
  input  logic [4:0]        cell_row_i,
  input  logic [4:0]        cell_col_i,
  input  logic [CELL_W-1:0] cell_value_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic              q_full_i,
  input  logic              clearing_i,
  output logic              busy_o,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic        accept;
  logic        in_map;
  logic [15:0] addr_full;

  assign busy_o = q_full_i | clearing_i;
  assign accept = start_i & ~busy_o;

  // A write outside the map is taken and dropped.
  assign in_map    = (9'(cell_row_i) < 9'(MAP_SIZE)) && (9'(cell_col_i) < 9'(MAP_SIZE));
  assign addr_full = 16'(cell_row_i) * 16'(MAP_SIZE) + 16'(cell_col_i);

  always_comb begin
    cmd_o.addr   = addr_full[ADDR_W-1:0];
    cmd_o.value  = cell_value_i;
    cmd_o.column = column_i;
    if (!action_i) begin
      cmd_o.kind = CMD_WRITE;
    end else if (13'(column_i) >= 13'(SCREEN_W)) begin
      cmd_o.kind = CMD_BAD;
    end else begin
      cmd_o.kind = CMD_CAST;
    end
  end

  assign push_o = accept & (action_i | in_map);

endmodule

// File: hdl/ddac_back.sv
// Back end: map clearing, cell writes, and the per-column ray sequencer.
module ddac_back import ddac_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cam_cfg_t                cfg_i,
  input  logic                    q_valid_i,
  input  cmd_t                    q_data_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    done_o,
  output logic [COL_W-1:0]        out_column_o,
  output logic signed [15:0]      draw_start_o,
  output logic signed [15:0]      draw_end_o,
  output logic                    hit_side_o,
  output logic                    hit_o
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CAM   = 5'd2;
  localparam logic [4:0] S_RAYX  = 5'd4;
  localparam logic [4:0] S_RAYY  = 5'd5;
  localparam logic [4:0] S_DX    = 5'd6;
  localparam logic [4:0] S_DXW   = 5'd7;
  localparam logic [4:0] S_DY    = 5'd8;
  localparam logic [4:0] S_DYW   = 5'd9;
  localparam logic [4:0] S_SX0   = 5'd10;
  localparam logic [4:0] S_SX1   = 5'd11;
  localparam logic [4:0] S_SY0   = 5'd12;
  localparam logic [4:0] S_SY1   = 5'd13;
  localparam logic [4:0] S_STEP  = 5'd14;
  localparam logic [4:0] S_CHECK = 5'd15;
  localparam logic [4:0] S_PERP  = 5'd16;
  localparam logic [4:0] S_PERPW = 5'd17;
  localparam logic [4:0] S_LH    = 5'd18;
  localparam logic [4:0] S_LHW   = 5'd19;

  localparam logic [DELTA_W-1:0] DELTA_SAT = DELTA_W'(1) << 40;

  logic [4:0]               state_q, state_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic signed [VEC_W-1:0]  cam_q, cam_d;
  logic signed [RAY_W-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic [DELTA_W-1:0]       dx_q, dx_d, dy_q, dy_d;
  logic [DELTA_W-1:0]       acc_q, acc_d;
  logic [SUM_W-1:0]         sx_q, sx_d, sy_q, sy_d;
  logic signed [COORD_W-1:0] mx_q, mx_d, my_q, my_d;
  logic [STEP_W-1:0]        n_q, n_d;
  logic                     side_q, side_d;
  logic                     neg_q, neg_d;
  logic [DIV_W-1:0]         perp_q, perp_d;

  logic                     done_q, done_d;
  logic [COL_W-1:0]         ocol_q, ocol_d;
  logic signed [15:0]       ds_q, ds_d, de_q, de_d;
  logic                     oside_q, oside_d, ohit_q, ohit_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [CELL_W-1:0]        ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]        ram_raddr;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dividend, div_divisor, div_quo;

  logic signed [24:0]       mul_a, mul_b;
  logic signed [49:0]       prod;
  logic [16:0]              fx, fy;
  logic [57:0]              side_sum;

  logic                     take_x;
  logic signed [COORD_W-1:0] nmx, nmy;
  logic                     oob;
  logic [2*COORD_W-1:0]     addr_full;
  logic signed [NUM_W-1:0]  num;
  logic signed [RAY_W-1:0]  ray_sel;
  logic [NUM_W-1:0]         num_mag;
  logic signed [DIV_W+1:0]  half, mid;

  ddac_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ddac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign prod = mul_a * mul_b;

  // Distance to the first grid line scales with the fraction toward it.
  assign fx = rx_q[RAY_W-1] ? {1'b0, cfg_i.pos_x[15:0]} : 17'(ONE_Q16) - 17'(cfg_i.pos_x[15:0]);
  assign fy = ry_q[RAY_W-1] ? {1'b0, cfg_i.pos_y[15:0]} : 17'(ONE_Q16) - 17'(cfg_i.pos_y[15:0]);

  // Next DDA cell and its map address.
  assign take_x = sx_q < sy_q;
  assign nmx = take_x ? (rx_q[RAY_W-1] ? mx_q - COORD_W'(1) : mx_q + COORD_W'(1)) : mx_q;
  assign nmy = take_x ? my_q : (ry_q[RAY_W-1] ? my_q - COORD_W'(1) : my_q + COORD_W'(1));
  assign oob = (nmx < 0) || (nmx >= COORD_W'(MAP_SIZE)) ||
               (nmy < 0) || (nmy >= COORD_W'(MAP_SIZE));
  assign addr_full = (2*COORD_W)'($unsigned(nmx)) * (2*COORD_W)'(MAP_SIZE) +
                     (2*COORD_W)'($unsigned(nmy));

  // Signed distance from the viewer to the crossed grid line.
  always_comb begin
    if (!side_q) begin
      num = (NUM_W'(mx_q) <<< 16) - NUM_W'(cfg_i.pos_x) +
            (rx_q[RAY_W-1] ? NUM_W'(ONE_Q16) : '0);
      ray_sel = rx_q;
    end else begin
      num = (NUM_W'(my_q) <<< 16) - NUM_W'(cfg_i.pos_y) +
            (ry_q[RAY_W-1] ? NUM_W'(ONE_Q16) : '0);
      ray_sel = ry_q;
    end
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // Wall slice rows around the screen middle.
  assign half = (DIV_W+2)'({1'b0, div_quo[DIV_W-1:1]});
  assign mid  = (DIV_W+2)'(SCREEN_H / 2);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    col_d    = col_q;
    cam_d    = cam_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    acc_d    = acc_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    mx_d     = mx_q;
    my_d     = my_q;
    n_d      = n_q;
    side_d   = side_q;
    neg_d    = neg_q;
    perp_d   = perp_q;
    done_d   = 1'b0;
    ocol_d   = ocol_q;
    ds_d     = ds_q;
    de_d     = de_q;
    oside_d  = oside_q;
    ohit_d   = ohit_q;
    pop_o    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = q_data_i.addr;
    ram_wdata = q_data_i.value;
    ram_raddr = addr_full[ADDR_W-1:0];
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_a = '0;
    mul_b = '0;
    side_sum = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          col_d = q_data_i.column;
          unique case (q_data_i.kind)
            CMD_WRITE: begin
              ram_we = 1'b1;
            end
            CMD_CAST: begin
              state_d = S_CAM;
            end
            default: begin
              done_d  = 1'b1;
              ocol_d  = q_data_i.column;
              ds_d    = '0;
              de_d    = '0;
              oside_d = 1'b0;
              ohit_d  = 1'b0;
            end
          endcase
        end
      end
      S_CAM: begin
        // Camera x from a reciprocal multiply of the column.
        mul_a   = 25'(col_q);
        mul_b   = 25'(CAM_RECIP);
        cam_d   = VEC_W'(prod[CAM_SHIFT+VEC_W-1:CAM_SHIFT]) - VEC_W'(ONE_Q16);
        state_d = S_RAYX;
      end
      S_RAYX: begin
        mul_a   = 25'(cfg_i.plane_x);
        mul_b   = 25'(cam_q);
        rx_d    = RAY_W'(cfg_i.dir_x) + prod[34:16];
        state_d = S_RAYY;
      end
      S_RAYY: begin
        mul_a   = 25'(cfg_i.plane_y);
        mul_b   = 25'(cam_q);
        ry_d    = RAY_W'(cfg_i.dir_y) + prod[34:16];
        state_d = S_DX;
      end
      S_DX: begin
        if (rx_q == '0) begin
          dx_d    = DELTA_SAT;
          state_d = S_DY;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(1) << 32;
          div_divisor  = DIV_W'(abs_ray(rx_q));
          state_d      = S_DXW;
        end
      end
      S_DXW: begin
        if (div_done) begin
          dx_d    = div_quo[DELTA_W-1:0];
          state_d = S_DY;
        end
      end
      S_DY: begin
        if (ry_q == '0) begin
          dy_d    = DELTA_SAT;
          state_d = S_SX0;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(1) << 32;
          div_divisor  = DIV_W'(abs_ray(ry_q));
          state_d      = S_DYW;
        end
      end
      S_DYW: begin
        if (div_done) begin
          dy_d    = div_quo[DELTA_W-1:0];
          state_d = S_SX0;
        end
      end
      S_SX0: begin
        mul_a   = 25'(fx);
        mul_b   = 25'(dx_q[23:0]);
        acc_d   = prod[DELTA_W-1:0];
        state_d = S_SX1;
      end
      S_SX1: begin
        mul_a    = 25'(fx);
        mul_b    = 25'(dx_q[40:24]);
        side_sum = 58'(acc_q) + (58'(prod[33:0]) << 24);
        sx_d     = SUM_W'(side_sum >> 16);
        state_d  = S_SY0;
      end
      S_SY0: begin
        mul_a   = 25'(fy);
        mul_b   = 25'(dy_q[23:0]);
        acc_d   = prod[DELTA_W-1:0];
        state_d = S_SY1;
      end
      S_SY1: begin
        mul_a    = 25'(fy);
        mul_b    = 25'(dy_q[40:24]);
        side_sum = 58'(acc_q) + (58'(prod[33:0]) << 24);
        sy_d     = SUM_W'(side_sum >> 16);
        mx_d     = COORD_W'(cfg_i.pos_x[POS_W-1:16]);
        my_d     = COORD_W'(cfg_i.pos_y[POS_W-1:16]);
        n_d      = '0;
        side_d   = 1'b0;
        state_d  = S_STEP;
      end
      S_STEP: begin
        if (take_x) begin
          sx_d   = sx_q + SUM_W'(dx_q);
          side_d = 1'b0;
        end else begin
          sy_d   = sy_q + SUM_W'(dy_q);
          side_d = 1'b1;
        end
        mx_d    = nmx;
        my_d    = nmy;
        state_d = oob ? S_PERP : S_CHECK;
      end
      S_CHECK: begin
        if (ram_rdata != '0) begin
          state_d = S_PERP;
        end else if (n_q == STEP_W'(MAX_STEPS - 1)) begin
          done_d  = 1'b1;
          ocol_d  = col_q;
          ds_d    = '0;
          de_d    = '0;
          oside_d = 1'b0;
          ohit_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          n_d     = n_q + 1'b1;
          state_d = S_STEP;
        end
      end
      S_PERP: begin
        if (ray_sel == '0) begin
          perp_d  = DIV_W'(1);
          state_d = S_LH;
        end else begin
          div_start    = 1'b1;
          div_dividend = {num_mag, 16'b0};
          div_divisor  = DIV_W'(abs_ray(ray_sel));
          neg_d        = num[NUM_W-1] ^ ray_sel[RAY_W-1];
          state_d      = S_PERPW;
        end
      end
      S_PERPW: begin
        if (div_done) begin
          // Distances that are not above zero saturate to one unit.
          perp_d  = (neg_q || div_quo == '0) ? DIV_W'(1) : div_quo;
          state_d = S_LH;
        end
      end
      S_LH: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(SCREEN_H * ONE_Q16);
        div_divisor  = perp_q;
        state_d      = S_LHW;
      end
      S_LHW: begin
        if (div_done) begin
          done_d  = 1'b1;
          ocol_d  = col_q;
          ds_d    = clamp16(mid - half);
          de_d    = clamp16(mid + half);
          oside_d = side_q;
          ohit_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    cam_q   <= cam_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    acc_q   <= acc_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    n_q     <= n_d;
    side_q  <= side_d;
    neg_q   <= neg_d;
    perp_q  <= perp_d;
    ocol_q  <= ocol_d;
    ds_q    <= ds_d;
    de_q    <= de_d;
    oside_q <= oside_d;
    ohit_q  <= ohit_d;
  end

  assign clearing_o   = state_q == S_CLEAR;
  assign done_o       = done_q;
  assign out_column_o = ocol_q;
  assign draw_start_o = ds_q;
  assign draw_end_o   = de_q;
  assign hit_side_o   = oside_q;
  assign hit_o        = ohit_q;

endmodule

// File: hdl/dda_ray_column_caster.sv
// Top level of the DDA ray column caster: camera registers, front, queue and back end.
// After reset the map is cleared by a pass over all MAP_SIZE*MAP_SIZE (1024) cells with busy_o high.
// A cell write and an off-screen column are handled in the back end's idle state; a cast takes
// four divisions (a zero ray component skips its own), the setup states, and the S_STEP and
// S_CHECK states for each DDA step before done_o.
// A two-entry queue lets later commands transfer; done_o pulses once and cannot be stalled.
module dda_ray_column_caster import ddac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 action_i,
  input  logic [4:0]           cell_row_i,
  input  logic [4:0]           cell_col_i,
  input  logic [CELL_W-1:0]    cell_value_i,
  input  logic [COL_W-1:0]     column_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 done_o,
  output logic [COL_W-1:0]     out_column_o,
  output logic signed [15:0]   draw_start_o,
  output logic signed [15:0]   draw_end_o,
  output logic                 hit_side_o,
  output logic                 hit_o
);

  cam_cfg_t cfg_q;
  logic     push, q_full, q_valid, pop, clearing;
  cmd_t     push_cmd, q_cmd;

  assign cfg_ready_o = 1'b1;

  // Camera register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x   <= POS_W'(1441792);
      cfg_q.pos_y   <= POS_W'(786432);
      cfg_q.dir_x   <= -18'sd65536;
      cfg_q.dir_y   <= '0;
      cfg_q.plane_x <= '0;
      cfg_q.plane_y <= 18'sd43254;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POS_X:   cfg_q.pos_x   <= cfg_data_i;
        REG_POS_Y:   cfg_q.pos_y   <= cfg_data_i;
        REG_DIR_X:   cfg_q.dir_x   <= cfg_data_i[VEC_W-1:0];
        REG_DIR_Y:   cfg_q.dir_y   <= cfg_data_i[VEC_W-1:0];
        REG_PLANE_X: cfg_q.plane_x <= cfg_data_i[VEC_W-1:0];
        REG_PLANE_Y: cfg_q.plane_y <= cfg_data_i[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  ddac_front u_front (
    .start_i      (start_i),
    .action_i     (action_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cell_value_i (cell_value_i),
    .column_i     (column_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .busy_o       (busy_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ddac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  ddac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_cmd),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .out_column_o (out_column_o),
    .draw_start_o (draw_start_o),
    .draw_end_o   (draw_end_o),
    .hit_side_o   (hit_side_o),
    .hit_o        (hit_o)
  );

endmodule

// File: tb/dda_ray_column_caster_tb.sv
// Self-checking testbench of the DDA ray column caster: map writes and column casts, checked against a predictor.
module dda_ray_column_caster_tb;
  import ddac_pkg::*;

  localparam bit ACT_WRITE = 1'b0;
  localparam bit ACT_CAST  = 1'b1;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;

  // One predicted column result.
  typedef struct {
    logic [COL_W-1:0] column;
    logic signed [15:0] row_first;
    logic signed [15:0] row_last;
    logic side;
    logic hit;
  } slice_t;

  // Predicts the wall slice of each cast and compares it with what the block returns.
  class cast_scoreboard;
    logic [CELL_W-1:0] cells[DEPTH];
    logic [POS_W-1:0] pos_x, pos_y;
    logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
    slice_t slices_due[$];
    int errors;

    function void clear_state();
      foreach (cells[i]) cells[i] = '0;
      pos_x = 21'd1441792;
      pos_y = 21'd786432;
      dir_x = -18'sd65536;
      dir_y = '0;
      plane_x = '0;
      plane_y = 18'sd43254;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
      case (idx)
        REG_POS_X:   pos_x = d;
        REG_POS_Y:   pos_y = d;
        REG_DIR_X:   dir_x = d[VEC_W-1:0];
        REG_DIR_Y:   dir_y = d[VEC_W-1:0];
        REG_PLANE_X: plane_x = d[VEC_W-1:0];
        REG_PLANE_Y: plane_y = d[VEC_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return slices_due.size();
    endfunction

    function longint delta_of(longint ray);
      longint m;
      if (ray == 0) return longint'(1) << 40;
      m = (ray < 0) ? -ray : ray;
      return (longint'(1) << 32) / m;
    endfunction

    function longint side_dist(logic [POS_W-1:0] pos, longint ray, longint delta);
      longint frac;
      frac = longint'(pos[15:0]);
      if (ray < 0) return (frac * delta) >> 16;
      return ((longint'(ONE_Q16) - frac) * delta) >> 16;
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v < -32768) return -16'sd32768;
      if (v > 32767) return 16'sd32767;
      return v[15:0];
    endfunction

    // Walks the map for one column and returns the slice it should draw.
    function slice_t trace(logic [COL_W-1:0] column);
      slice_t s;
      longint cam, rx, ry, mx, my, dx, dy, sx, sy, num, ray, perp, lh;
      int stx, sty, side, found;
      s.column = column;
      s.row_first = '0;
      s.row_last = '0;
      s.side = 1'b0;
      s.hit = 1'b0;
      if (column >= SCREEN_W) return s;
      cam = (2 * longint'(column) * ONE_Q16) / SCREEN_W - ONE_Q16;
      rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
      ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
      mx = longint'(pos_x >> 16);
      my = longint'(pos_y >> 16);
      dx = delta_of(rx);
      dy = delta_of(ry);
      sx = side_dist(pos_x, rx, dx);
      sy = side_dist(pos_y, ry, dy);
      stx = (rx < 0) ? -1 : 1;
      sty = (ry < 0) ? -1 : 1;
      side = 0;
      found = 0;
      for (int n = 0; n < MAX_STEPS && found == 0; n++) begin
        if (sx < sy) begin
          sx += dx;
          mx += stx;
          side = 0;
        end else begin
          sy += dy;
          my += sty;
          side = 1;
        end
        // Leaving the map counts as a wall.
        if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) found = 1;
        else if (cells[mx * MAP_SIZE + my] != 0) found = 1;
      end
      if (found == 0) return s;
      if (side == 0) begin
        num = mx * ONE_Q16 - longint'(pos_x) + ((stx < 0) ? ONE_Q16 : 0);
        ray = rx;
      end else begin
        num = my * ONE_Q16 - longint'(pos_y) + ((sty < 0) ? ONE_Q16 : 0);
        ray = ry;
      end
      perp = (ray != 0) ? (num * ONE_Q16) / ray : 0;
      if (perp <= 0) perp = 1;
      lh = (longint'(SCREEN_H) * ONE_Q16) / perp;
      s.row_first = sat16(SCREEN_H / 2 - lh / 2);
      s.row_last = sat16(SCREEN_H / 2 + lh / 2);
      s.side = side[0];
      s.hit = 1'b1;
      return s;
    endfunction

    // Records one accepted item: a write updates the map, a cast queues its slice.
    function void note(bit act, logic [4:0] row, logic [4:0] col, logic [CELL_W-1:0] val,
                       logic [COL_W-1:0] column);
      if (act == ACT_WRITE) cells[row * MAP_SIZE + col] = val;
      else slices_due.push_back(trace(column));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(logic [COL_W-1:0] column, logic signed [15:0] row_first,
               logic signed [15:0] row_last, logic side, logic hit);
      slice_t e;
      if (slices_due.size() == 0) begin
        report($sformatf("unexpected result for column %0d", column));
        return;
      end
      e = slices_due.pop_front();
      if (column !== e.column || row_first !== e.row_first || row_last !== e.row_last ||
          side !== e.side || hit !== e.hit)
        report($sformatf("col %0d/%0d start %0d/%0d end %0d/%0d side %0b/%0b hit %0b/%0b",
                         column, e.column, row_first, e.row_first, row_last, e.row_last,
                         side, e.side, hit, e.hit));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic action_i = 1'b0;
  logic [4:0] cell_row_i = '0;
  logic [4:0] cell_col_i = '0;
  logic [CELL_W-1:0] cell_value_i = '0;
  logic [COL_W-1:0] column_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [COL_W-1:0] out_column_o;
  logic signed [15:0] draw_start_o;
  logic signed [15:0] draw_end_o;
  logic hit_side_o;
  logic hit_o;

  cast_scoreboard sb = new();
  int cycles = 0;

  dda_ray_column_caster u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every done pulse is a result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check(out_column_o, draw_start_o, draw_end_o, hit_side_o, hit_o);
  end

  // Presents one item and waits for its transfer; start stays high afterwards.
  task automatic send_item(bit act, logic [4:0] row, logic [4:0] col,
                           logic [CELL_W-1:0] val, logic [COL_W-1:0] column);
    action_i = act;
    cell_row_i = row;
    cell_col_i = col;
    cell_value_i = val;
    column_i = column;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note(act, row, col, val, column);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    cfg_index_i = idx;
    cfg_data_i = d;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drains all casts, then leaves room for a trailing cell write.
  task automatic settle();
    start_i = 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_camera(logic [20:0] px, logic [20:0] py, logic [17:0] dx,
                             logic [17:0] dy, logic [17:0] plx, logic [17:0] ply);
    settle();
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_DIR_X, {3'b0, dx});
    write_reg(REG_DIR_Y, {3'b0, dy});
    write_reg(REG_PLANE_X, {3'b0, plx});
    write_reg(REG_PLANE_Y, {3'b0, ply});
  endtask

  // Random mix of map writes and casts, sent in bursts, with random gaps between bursts when gaps is set.
  task automatic random_items(int count, bit gaps);
    int burst;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3)
        send_item(ACT_WRITE, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  ($urandom_range(0, 9) < 4) ? 4'd0 : 4'($urandom_range(1, 15)), 12'($urandom));
      else
        send_item(ACT_CAST, 5'($urandom), 5'($urandom), 4'($urandom),
                  ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 799)));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        if (gaps) begin
          start_i = 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk_i);
        end
      end
    end
  endtask

  initial begin
    int wait_cycles;
    sb.clear_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset camera: map corners, a wall ahead, screen edges.
    send_item(ACT_WRITE, 5'd0, 5'd0, 4'd15, 12'd0);
    send_item(ACT_WRITE, 5'd31, 5'd31, 4'd15, 12'hFFF);
    send_item(ACT_CAST, 5'd31, 5'd31, 4'd15, 12'd0);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd799);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd800);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd4095);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd400);
    send_item(ACT_WRITE, 5'd10, 5'd12, 4'd5, 12'd0);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd400);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd1);
    send_item(ACT_WRITE, 5'd21, 5'd12, 4'd1, 12'd0);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd400);
    send_item(ACT_WRITE, 5'd21, 5'd12, 4'd0, 12'd0);
    send_item(ACT_WRITE, 5'd10, 5'd12, 4'd0, 12'd0);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd2048);
    random_items(60, 1'b1);

    // Zero x ray component; column 400 gives a zero camera x.
    load_camera(21'd655360, 21'd655360, 18'd0, 18'd65536, 18'd0, 18'd43254);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd400);
    send_item(ACT_CAST, 5'd0, 5'd0, 4'd0, 12'd0);
    random_items(80, 1'b0);

    // Extreme registers: the map corners and the widest vectors.
    load_camera(21'd0, 21'd0, 18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF);
    random_items(80, 1'b1);
    load_camera(21'h1FFFFF, 21'h1FFFFF, 18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000);
    random_items(80, 1'b1);

    // Random camera settings.
    for (int p = 0; p < 4; p++) begin
      load_camera(21'($urandom), 21'($urandom), 18'($urandom), 18'($urandom),
                  18'($urandom), 18'($urandom));
      random_items(85, p[0]);
    end

    start_i = 1'b0;
    wait_cycles = 0;
    while (sb.pending() > 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: dda_ray_column_caster.f
hdl/ddac_pkg.sv
hdl/ddac_ram.sv
hdl/ddac_div.sv
hdl/ddac_queue.sv
hdl/ddac_front.sv
hdl/ddac_back.sv
hdl/dda_ray_column_caster.sv
tb/dda_ray_column_caster_tb.sv
